// ----- hdl/abae_pkg.sv -----
package abae_pkg;

    // Field widths that the stream format fixes.
    localparam int CNT_W       = 16;
    localparam int WIN_W       = 15;
    localparam int WORD_W      = 24;
    localparam int CTX_IDX_W   = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    // Window register reset value and the smallest usable window.
    localparam logic [WIN_W-1:0] WIN_RESET = 15'd1024;
    localparam logic [WIN_W-1:0] WIN_MIN   = 15'd2;

    // Operation codes carried in s_tuser.
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // One context entry: adaptive counts and the window snapshot.
    typedef struct packed {
        logic [CNT_W-1:0] snap_total;
        logic [CNT_W-1:0] snap_zero;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] zero;
    } ctx_entry_t;

    localparam ctx_entry_t CTX_RESET = '{
        snap_total: 16'd0,
        snap_zero:  16'd0,
        total:      16'd2,
        zero:       16'd1
    };

    // Request from the sequencer to the split divider.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] zero;
        logic [CNT_W-1:0] total;
    } div_req_t;

    // Count adaptation with sliding-window halving. Count updates wrap at 16 bits.
    function automatic ctx_entry_t adapt_entry(ctx_entry_t cur, logic one,
                                               logic [WIN_W-1:0] win);
        logic [CNT_W:0] w;
        logic [CNT_W:0] limit;
        ctx_entry_t     r;
        w     = (win < WIN_MIN) ? {2'b00, WIN_MIN} : {2'b00, win};
        limit = (w << 1) - 17'd2;
        r     = cur;
        if ({1'b0, cur.total} == w) begin
            r.snap_zero  = cur.zero;
            r.snap_total = cur.total;
        end
        if (!one) begin
            r.zero = r.zero + 16'd1;
        end
        r.total = r.total + 16'd1;
        if ({1'b0, r.total} >= limit) begin
            r.zero  = r.zero - (r.snap_zero - 16'd1);
            r.total = r.total - (r.snap_total - 16'd2);
        end
        return r;
    endfunction

endpackage

// ----- hdl/abae_ctx_ram.sv -----
module abae_ctx_ram #(
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output abae_pkg::ctx_entry_t  rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  abae_pkg::ctx_entry_t  wr_data,
    output logic                  ready
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    abae_pkg::ctx_entry_t mem [DEPTH];
    abae_pkg::ctx_entry_t rd_data_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic                 ready_reg;

    // Clearing sweep after reset: one entry per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            ready_reg    <= 1'b0;
        end else if (!ready_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                ready_reg <= 1'b1;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Single write port, shared between the sweep and the count write-back.
    always_ff @(posedge aclk) begin
        if (!ready_reg) begin
            mem[clr_addr_reg] <= abae_pkg::CTX_RESET;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = ready_reg;

endmodule

// ----- hdl/abae_div.sv -----
module abae_div #(
    parameter int RANGE_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  abae_pkg::div_req_t    req,
    input  logic [RANGE_BITS-1:0] width,
    output logic                  done,
    output logic [RANGE_BITS-1:0] split
);

    localparam int PW = RANGE_BITS + abae_pkg::CNT_W;
    localparam int CW = $clog2(RANGE_BITS + 1);
    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_LOAD = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    logic [1:0]                  state_reg;
    logic [PW-1:0]               prod_reg;
    logic                        sat_reg;
    logic [RANGE_BITS-1:0]       width_reg;
    logic [abae_pkg::CNT_W-1:0]  total_reg;
    logic [abae_pkg::CNT_W-1:0]  rem_reg;
    logic [RANGE_BITS-1:0]       quot_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        done_reg;
    logic [abae_pkg::CNT_W:0]    rem_shift;
    logic                        quot_bit;

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign rem_shift = {rem_reg, quot_reg[RANGE_BITS-1]};
    assign quot_bit  = (rem_shift >= {1'b0, total_reg});

    // Sequencer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        state_reg <= D_LOAD;
                    end
                end
                D_LOAD: begin
                    cnt_reg   <= CW'(RANGE_BITS);
                    state_reg <= D_RUN;
                end
                D_RUN: begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    // Datapath: registered product, then one quotient bit per cycle.
    // When zero >= total the quotient is at least the width, so it saturates.
    always_ff @(posedge aclk) begin
        if (state_reg == D_IDLE && req.start) begin
            prod_reg  <= PW'(width) * PW'(req.zero);
            sat_reg   <= (req.zero >= req.total);
            width_reg <= width;
            total_reg <= req.total;
        end else if (state_reg == D_LOAD) begin
            rem_reg  <= prod_reg[PW-1:RANGE_BITS];
            quot_reg <= prod_reg[RANGE_BITS-1:0];
        end else if (state_reg == D_RUN) begin
            rem_reg  <= quot_bit ? rem_shift[abae_pkg::CNT_W-1:0] - total_reg
                                 : rem_shift[abae_pkg::CNT_W-1:0];
            quot_reg <= {quot_reg[RANGE_BITS-2:0], quot_bit};
        end
    end

    assign done  = done_reg;
    assign split = sat_reg ? width_reg : quot_reg;

endmodule

// ----- hdl/adaptive_binary_arith_encoder.sv -----
// Adaptive binary arithmetic encoder.
// Input stream (s_*): s_tuser is the operation (0 = encode a bit, 1 = flush);
// s_tdata carries the bit and three 4-bit context indices that pick one entry
// of the adaptive count memory. Output stream (m_*): m_tdata is a 24-bit code
// word, m_tuser flags the final word produced by a flush.
// An encode transaction occupies the block from its accept to the next accept
// with these steps in order: the accept, a memory read, the multiply, a divider
// load, RANGE_BITS restoring divider steps, a done step and a write-back. When
// a word results, the emit state after the write-back loads it into the output
// register. A flush goes from its accept straight to the emit state, which
// loads its word. s_tready is low while the block works.
// The window length is written through cfg_wr_en/cfg_wr_data; the user must
// do so only while idle, since the block itself does not enforce it.
// After reset the count memory is swept to its initial values, one entry per
// cycle (CTX_A_SIZE * CTX_B_SIZE * CTX_C_SIZE entries, 4096 by default);
// s_tready stays low during the sweep. A finished word sits in the output
// register until taken; the next transaction is still accepted meanwhile,
// and the block waits only when a second word is ready before the first left.
module adaptive_binary_arith_encoder #(
    parameter int CTX_A_SIZE = 16,
    parameter int CTX_B_SIZE = 16,
    parameter int CTX_C_SIZE = 16,
    parameter int RANGE_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [abae_pkg::WIN_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] symbol_bit, [4:1] ctx_first, [8:5] ctx_second, [12:9] ctx_third
    input  logic [abae_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] opcode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] code_word
    output logic [abae_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] is_final
    output logic                              m_tuser
);

    localparam int DEPTH = CTX_A_SIZE * CTX_B_SIZE * CTX_C_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int A_W   = (CTX_A_SIZE > 1) ? $clog2(CTX_A_SIZE) : 1;
    localparam int B_W   = (CTX_B_SIZE > 1) ? $clog2(CTX_B_SIZE) : 1;
    localparam int C_W   = (CTX_C_SIZE > 1) ? $clog2(CTX_C_SIZE) : 1;
    localparam int IDX_N = 1 << abae_pkg::CTX_IDX_W;
    localparam logic [RANGE_BITS-1:0] RANGE_ONES = {RANGE_BITS{1'b1}};

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_START  = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [abae_pkg::WIN_W-1:0]      win_reg;
    logic [RANGE_BITS-1:0]           low_reg;
    logic [RANGE_BITS-1:0]           width_reg;
    logic [AW-1:0]                   addr_reg;
    logic                            bit_reg;
    logic [abae_pkg::WORD_W-1:0]     word_reg;
    logic                            final_reg;
    logic                            m_tvalid_reg;
    logic [abae_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                            m_tuser_reg;

    logic                            in_fire;
    logic                            out_free;
    logic                            ram_ready;
    abae_pkg::ctx_entry_t            rd_data;
    abae_pkg::ctx_entry_t            wr_data;
    abae_pkg::div_req_t              div_req;
    logic                            div_done;
    logic [RANGE_BITS-1:0]           split;
    logic [RANGE_BITS-1:0]           low_new;
    logic [RANGE_BITS-1:0]           width_new;
    logic [RANGE_BITS+abae_pkg::WORD_W-1:0] low_new_ext;
    logic [RANGE_BITS+abae_pkg::WORD_W-1:0] low_cur_ext;
    logic [31:0]                     addr_full;
    logic [abae_pkg::CTX_IDX_W-1:0]  idx_a;
    logic [abae_pkg::CTX_IDX_W-1:0]  idx_b;
    logic [abae_pkg::CTX_IDX_W-1:0]  idx_c;
    logic [A_W-1:0]                  mod_a [IDX_N];
    logic [B_W-1:0]                  mod_b [IDX_N];
    logic [C_W-1:0]                  mod_c [IDX_N];

    // Context index reduction tables, one entry per 4-bit index value.
    for (genvar v = 0; v < IDX_N; v++) begin : g_mod
        localparam int RA = v % CTX_A_SIZE;
        localparam int RB = v % CTX_B_SIZE;
        localparam int RC = v % CTX_C_SIZE;
        assign mod_a[v] = A_W'(RA);
        assign mod_b[v] = B_W'(RB);
        assign mod_c[v] = C_W'(RC);
    end

    // Entry address of the incoming transaction.
    assign idx_a     = s_tdata[4:1];
    assign idx_b     = s_tdata[8:5];
    assign idx_c     = s_tdata[12:9];
    assign addr_full = (32'(mod_a[idx_a]) * 32'(CTX_B_SIZE) + 32'(mod_b[idx_b]))
                       * 32'(CTX_C_SIZE) + 32'(mod_c[idx_c]);

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Range update from the split point.
    always_comb begin
        if (bit_reg) begin
            low_new   = low_reg + split + RANGE_BITS'(1);
            width_new = width_reg - split - RANGE_BITS'(1);
        end else begin
            low_new   = low_reg;
            width_new = split;
        end
    end

    assign low_new_ext = {{abae_pkg::WORD_W{1'b0}}, low_new};
    assign low_cur_ext = {{abae_pkg::WORD_W{1'b0}}, low_reg};

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (ram_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_tuser == abae_pkg::OP_FLUSH) ? ST_EMIT : ST_READ;
                end
            end
            ST_READ:  state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = (width_new == '0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Control and coder state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            win_reg   <= abae_pkg::WIN_RESET;
            low_reg   <= '0;
            width_reg <= RANGE_ONES;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                win_reg <= cfg_wr_data;
            end
            if (in_fire && s_tuser == abae_pkg::OP_FLUSH) begin
                low_reg   <= '0;
                width_reg <= RANGE_ONES;
            end else if (state_reg == ST_UPDATE) begin
                if (width_new == '0) begin
                    low_reg   <= '0;
                    width_reg <= RANGE_ONES;
                end else begin
                    low_reg   <= low_new;
                    width_reg <= width_new;
                end
            end
        end
    end

    // Transaction payload and pending word.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            addr_reg  <= addr_full[AW-1:0];
            bit_reg   <= s_tdata[0];
            word_reg  <= low_cur_ext[abae_pkg::WORD_W-1:0];
            final_reg <= 1'b1;
        end else if (state_reg == ST_UPDATE) begin
            word_reg  <= low_new_ext[abae_pkg::WORD_W-1:0];
            final_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_tdata_reg <= word_reg;
            m_tuser_reg <= final_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Count memory and the shared divider.
    assign wr_data       = abae_pkg::adapt_entry(rd_data, bit_reg, win_reg);
    assign div_req.start = (state_reg == ST_START);
    assign div_req.zero  = rd_data.zero;
    assign div_req.total = rd_data.total;

    abae_ctx_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (addr_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .ready   (ram_ready)
    );

    abae_div #(
        .RANGE_BITS (RANGE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .width   (width_reg),
        .done    (div_done),
        .split   (split)
    );

endmodule

// ----- hdl/abae_checker.sv -----
module abae_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [abae_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tuser
);

    // Reset starts the memory sweep and empties the output register.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> (!s_tready && !m_tvalid))
        else $error("block not quiet after reset");

    // One transaction at a time: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while busy");

    // A flush into an empty output register passes the emit state and then shows its final word.
    a_flush_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == abae_pkg::OP_FLUSH && !m_tvalid)
        |=> ##1 (m_tvalid && m_tuser))
        else $error("flush did not produce a final word");

    // A stalled word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output changed while stalled");

endmodule

bind adaptive_binary_arith_encoder abae_checker u_abae_checker (.*);
